/* rtl/core/hsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types for the heat stencil cell update: microcode word, datapath
// control bundle and the microcode program itself.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    A_DW,
    A_DE,
    A_DN,
    A_DS,
    A_MLO,
    A_MHI
  } a_sel_t;

  typedef enum logic [1:0] {
    B_KW,
    B_KC,
    B_KN,
    B_GAIN
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_S_FIRST,
    ACC_S_ADD,
    ACC_ABS,
    ACC_G_FIRST,
    ACC_G_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT_IN,
    J_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    jmp_t              jmp;
    logic [PC_W-1:0]   target;
  } ucode_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    acc_op_t acc_op;
    logic    load;
    logic    fire;
  } dp_ctl_t;

  localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] ST_MUL_W  = 4'd1;
  localparam logic [PC_W-1:0] ST_MUL_E  = 4'd2;
  localparam logic [PC_W-1:0] ST_MUL_N  = 4'd3;
  localparam logic [PC_W-1:0] ST_MUL_S  = 4'd4;
  localparam logic [PC_W-1:0] ST_SUM    = 4'd5;
  localparam logic [PC_W-1:0] ST_ABS    = 4'd6;
  localparam logic [PC_W-1:0] ST_GLO    = 4'd7;
  localparam logic [PC_W-1:0] ST_GHI    = 4'd8;
  localparam logic [PC_W-1:0] ST_GSUM   = 4'd9;
  localparam logic [PC_W-1:0] ST_OUT    = 4'd10;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{a_sel: A_DW, b_sel: B_KW, acc_op: ACC_NONE, jmp: J_NEXT, target: ST_IDLE};
    case (pc)
      ST_IDLE:  w.jmp = J_WAIT_IN;
      ST_MUL_W: begin
        w.a_sel = A_DW;
        w.b_sel = B_KW;
      end
      ST_MUL_E: begin
        w.a_sel  = A_DE;
        w.b_sel  = B_KC;
        w.acc_op = ACC_S_FIRST;
      end
      ST_MUL_N: begin
        w.a_sel  = A_DN;
        w.b_sel  = B_KN;
        w.acc_op = ACC_S_ADD;
      end
      ST_MUL_S: begin
        w.a_sel  = A_DS;
        w.b_sel  = B_KC;
        w.acc_op = ACC_S_ADD;
      end
      ST_SUM:   w.acc_op = ACC_S_ADD;
      ST_ABS:   w.acc_op = ACC_ABS;
      ST_GLO: begin
        w.a_sel = A_MLO;
        w.b_sel = B_GAIN;
      end
      ST_GHI: begin
        w.a_sel  = A_MHI;
        w.b_sel  = B_GAIN;
        w.acc_op = ACC_G_FIRST;
      end
      ST_GSUM:  w.acc_op = ACC_G_ADD;
      ST_OUT: begin
        w.jmp    = J_WAIT_OUT;
        w.target = ST_IDLE;
      end
      default: begin
        w.jmp    = J_WAIT_OUT;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/heat_stencil_cell_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_stencil_cell_update
// Explicit five-point heat stencil update of one grid cell per request, with
// a running sweep residual and convergence flag.
// ----------------------------------------------------------------------------
// out_valid is registered when the program's output step fires, which waits
// until the result port is free. The 11-step microcode program runs six
// products through the single shared multiplier; a new request is taken only in idle.
// A waiting result does not block the next request; the sequencer holds only
// if a second result is ready while the first is still not taken.
// Synchronous reset clears the sequencer, the result valid and the residual,
// and loads step_gain and converge_threshold with their reset values.
// ----------------------------------------------------------------------------
module heat_stencil_cell_update #(
  parameter int TEMP_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [TEMP_WIDTH-1:0] in_centre_temp,
  input  logic signed [TEMP_WIDTH-1:0] in_west_temp,
  input  logic signed [TEMP_WIDTH-1:0] in_east_temp,
  input  logic signed [TEMP_WIDTH-1:0] in_north_temp,
  input  logic signed [TEMP_WIDTH-1:0] in_south_temp,
  input  logic [15:0]                  in_west_conductivity,
  input  logic [15:0]                  in_centre_conductivity,
  input  logic [15:0]                  in_north_conductivity,
  input  logic                         in_last_of_sweep,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [TEMP_WIDTH-1:0] out_new_temp,
  output logic [30:0]                  out_abs_change,
  output logic [30:0]                  out_sweep_residual,
  output logic                         out_converged,
  output logic                         out_sweep_done,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import hsc_pkg::*;

  dp_ctl_t                      ctl;
  logic                         out_free;
  logic [23:0]                  step_gain;
  logic [30:0]                  converge_threshold;
  logic signed [TEMP_WIDTH-1:0] dp_new_temp;
  logic [30:0]                  dp_abs_change;

  logic                         last_r;
  logic [30:0]                  run_r;
  logic [30:0]                  run_nxt;
  logic [30:0]                  res_new;
  logic                         out_valid_r;
  logic signed [TEMP_WIDTH-1:0] out_new_temp_r;
  logic [30:0]                  out_abs_change_r;
  logic [30:0]                  out_sweep_residual_r;
  logic                         out_converged_r;
  logic                         out_sweep_done_r;

  hsc_cfg u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .step_gain          (step_gain),
    .converge_threshold (converge_threshold)
  );

  hsc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  hsc_dp #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .ctl                 (ctl),
    .centre_temp         (in_centre_temp),
    .west_temp           (in_west_temp),
    .east_temp           (in_east_temp),
    .north_temp          (in_north_temp),
    .south_temp          (in_south_temp),
    .west_conductivity   (in_west_conductivity),
    .centre_conductivity (in_centre_conductivity),
    .north_conductivity  (in_north_conductivity),
    .step_gain           (step_gain),
    .new_temp            (dp_new_temp),
    .abs_change          (dp_abs_change)
  );

  assign out_free = ~out_valid_r | out_ready;
  assign res_new  = (dp_abs_change > run_r) ? dp_abs_change : run_r;
  assign run_nxt  = last_r ? '0 : res_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      if (ctl.fire) begin
        out_valid_r <= 1'b1;
        run_r       <= run_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last_r <= in_last_of_sweep;
    end
    if (ctl.fire) begin
      out_new_temp_r       <= dp_new_temp;
      out_abs_change_r     <= dp_abs_change;
      out_sweep_residual_r <= res_new;
      out_converged_r      <= last_r & (res_new <= converge_threshold);
      out_sweep_done_r     <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_new_temp       = out_new_temp_r;
  assign out_abs_change     = out_abs_change_r;
  assign out_sweep_residual = out_sweep_residual_r;
  assign out_converged      = out_converged_r;
  assign out_sweep_done     = out_sweep_done_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while sequencer busy");

  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire |=> out_valid_r)
    else $error("result lost after fire");

  a_sweep_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.fire && last_r) |=> (run_r == '0))
    else $error("residual not cleared at end of sweep");

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_abs_change_r <= out_sweep_residual_r))
    else $error("residual below cell change");

  a_conv_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_converged_r) |-> out_sweep_done_r)
    else $error("converged flag off the last cell");

endmodule

/* rtl/core/hsc_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_cfg
// Configuration register file: step gain and convergence threshold.
// ----------------------------------------------------------------------------
module hsc_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [23:0] step_gain,
  output logic [30:0] converge_threshold
);

  localparam logic [23:0] GAIN_RST = 24'd190650;
  localparam logic [30:0] THR_RST  = 31'd7;
  localparam logic        REG_GAIN = 1'b0;
  localparam logic        REG_THR  = 1'b1;

  logic [23:0] gain_r;
  logic [30:0] thr_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      thr_r  <= THR_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_GAIN) gain_r <= pwdata[23:0];
      if (paddr[2] == REG_THR)  thr_r  <= pwdata[30:0];
    end
  end

  assign prdata = (paddr[2] == REG_THR) ? {1'b0, thr_r} : {8'b0, gain_r};

  assign step_gain          = gain_r;
  assign converge_threshold = thr_r;

endmodule

/* rtl/core/hsc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_seq
// Microcode sequencer: step counter over the control ROM, with waits on the
// request and result handshakes.
// ----------------------------------------------------------------------------
module hsc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             out_free,
  output logic             in_ready,
  output hsc_pkg::dp_ctl_t ctl
);
  import hsc_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ucode_t          uw;

  assign uw = ucode(pc_r);

  assign in_ready   = (uw.jmp == J_WAIT_IN);
  assign ctl.a_sel  = uw.a_sel;
  assign ctl.b_sel  = uw.b_sel;
  assign ctl.acc_op = uw.acc_op;
  assign ctl.load   = in_ready & in_valid;
  assign ctl.fire   = (uw.jmp == J_WAIT_OUT) & out_free;

  always_comb begin
    case (uw.jmp)
      J_NEXT:     pc_nxt = pc_r + PC_W'(1);
      J_WAIT_IN:  pc_nxt = in_valid ? pc_r + PC_W'(1) : pc_r;
      J_WAIT_OUT: pc_nxt = out_free ? uw.target : pc_r;
      default:    pc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

/* rtl/core/hsc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_dp
// Stencil datapath: one shared signed multiplier, the flux accumulator, the
// gain accumulator with rounding, and the saturating result logic.
// ----------------------------------------------------------------------------
module hsc_dp #(
  parameter int TEMP_WIDTH = 32
) (
  input  logic                         clk,
  input  hsc_pkg::dp_ctl_t             ctl,
  input  logic signed [TEMP_WIDTH-1:0] centre_temp,
  input  logic signed [TEMP_WIDTH-1:0] west_temp,
  input  logic signed [TEMP_WIDTH-1:0] east_temp,
  input  logic signed [TEMP_WIDTH-1:0] north_temp,
  input  logic signed [TEMP_WIDTH-1:0] south_temp,
  input  logic [15:0]                  west_conductivity,
  input  logic [15:0]                  centre_conductivity,
  input  logic [15:0]                  north_conductivity,
  input  logic [23:0]                  step_gain,
  output logic signed [TEMP_WIDTH-1:0] new_temp,
  output logic [30:0]                  abs_change
);
  import hsc_pkg::*;

  localparam int W    = TEMP_WIDTH;
  localparam int DIFW = W + 1;
  localparam int SW   = W + 20;
  localparam int H    = (SW + 1) / 2;
  localparam int MA   = (DIFW > H + 1) ? DIFW : H + 1;
  localparam int BW   = 25;
  localparam int PW   = MA + BW;
  localparam int GW   = SW + 25;
  localparam int DMW  = GW - 32;
  localparam int NW   = DMW + 2;
  localparam int XW   = (DMW > 32) ? DMW : 32;

  localparam logic [GW-1:0]       ROUND  = GW'(1) << 31;
  localparam logic signed [W-1:0] TMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] TMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic [30:0]         RES_MAX = 31'h7FFF_FFFF;

  logic signed [W-1:0]    c_r;
  logic signed [DIFW-1:0] d_r [4];
  logic [15:0]            kw_r;
  logic [15:0]            kc_r;
  logic [15:0]            kn_r;
  logic signed [SW-1:0]   s_r;
  logic [SW-1:0]          mag_r;
  logic                   sneg_r;
  logic signed [PW-1:0]   p_r;
  logic [GW-1:0]          g_r;

  logic signed [MA-1:0]   a_mux;
  logic signed [BW-1:0]   b_mux;
  logic [DMW-1:0]         dmag;
  logic signed [NW-1:0]   cx;
  logic signed [NW-1:0]   dx;
  logic signed [NW-1:0]   nt;
  logic [XW-1:0]          dmag_x;

  always_comb begin
    case (ctl.a_sel)
      A_DW:    a_mux = MA'(d_r[0]);
      A_DE:    a_mux = MA'(d_r[1]);
      A_DN:    a_mux = MA'(d_r[2]);
      A_DS:    a_mux = MA'(d_r[3]);
      A_MLO:   a_mux = $signed(MA'(mag_r[H-1:0]));
      A_MHI:   a_mux = $signed(MA'(mag_r[SW-1:H]));
      default: a_mux = '0;
    endcase
  end

  always_comb begin
    case (ctl.b_sel)
      B_KW:    b_mux = $signed({9'b0, kw_r});
      B_KC:    b_mux = $signed({9'b0, kc_r});
      B_KN:    b_mux = $signed({9'b0, kn_r});
      B_GAIN:  b_mux = $signed({1'b0, step_gain});
      default: b_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c_r    <= centre_temp;
      d_r[0] <= DIFW'(west_temp)  - DIFW'(centre_temp);
      d_r[1] <= DIFW'(east_temp)  - DIFW'(centre_temp);
      d_r[2] <= DIFW'(north_temp) - DIFW'(centre_temp);
      d_r[3] <= DIFW'(south_temp) - DIFW'(centre_temp);
      kw_r   <= west_conductivity;
      kc_r   <= centre_conductivity;
      kn_r   <= north_conductivity;
    end
    p_r <= a_mux * b_mux;
    case (ctl.acc_op)
      ACC_S_FIRST: s_r <= SW'(p_r);
      ACC_S_ADD:   s_r <= s_r + SW'(p_r);
      ACC_ABS: begin
        sneg_r <= s_r[SW-1];
        mag_r  <= s_r[SW-1] ? $unsigned(-s_r) : $unsigned(s_r);
      end
      ACC_G_FIRST: g_r <= GW'($unsigned(p_r)) + ROUND;
      ACC_G_ADD:   g_r <= g_r + (GW'($unsigned(p_r)) << H);
      default: ;
    endcase
  end

  assign dmag = g_r[GW-1:32];
  assign cx   = NW'(c_r);
  assign dx   = $signed({2'b00, dmag});
  assign nt   = sneg_r ? cx - dx : cx + dx;

  always_comb begin
    if (nt > NW'(TMAX_W)) begin
      new_temp = TMAX_W;
    end else if (nt < NW'(TMIN_W)) begin
      new_temp = TMIN_W;
    end else begin
      new_temp = $signed(nt[W-1:0]);
    end
  end

  assign dmag_x     = XW'(dmag);
  assign abs_change = (|dmag_x[XW-1:31]) ? RES_MAX : dmag_x[30:0];

endmodule
